### sv/capm_pkg.sv
`timescale 1ns / 1ps
package capm_pkg;

  localparam int COORD_W = 24;
  localparam int THR_W   = 23;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * COORD_W + 1;
  localparam int DIST_W  = SQ_W + 1;
  localparam int T2_W    = 2 * THR_W;
  localparam int MIN_LIST = 3;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(16);

  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_THR,
    S_T2,
    S_RD,
    S_DX,
    S_DY,
    S_ADD,
    S_CMP,
    S_ERD,
    S_EOUT
  } state_t;

  function automatic logic signed [COORD_W-1:0] floor_mid(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    logic signed [DIFF_W-1:0] s;
    s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    return s[DIFF_W-1:1];
  endfunction

  function automatic logic signed [DIFF_W-1:0] sdiff(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    return {a[COORD_W-1], a} - {b[COORD_W-1], b};
  endfunction

endpackage

### sv/capm_sq.sv
`timescale 1ns / 1ps
module capm_sq (
  input  logic                                clk,
  input  logic signed [capm_pkg::DIFF_W-1:0]  a,
  output logic        [capm_pkg::SQ_W-1:0]    sq
);
  import capm_pkg::*;

  logic signed [2*DIFF_W-1:0] full;

  assign full = a * a;

  always_ff @(posedge clk) begin
    sq <= full[SQ_W-1:0];
  end

endmodule

### sv/closest_adjacent_point_merge.sv
`timescale 1ns / 1ps
// A point that is not the last of its list is taken and stored.
// The last point of a list of three or more starts a scan through one shared multiplier;
// then each point is read from memory and loaded into the output register.
// The input is held off from the last point until the last result is in the output register.
// Reset clears the state, the point count and the output valid, and sets the threshold to 16.
// The point memory is not cleared; only entries written in the current list are read.
module closest_adjacent_point_merge #(
  parameter int MAX_POINTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // point_x [23:0], point_y [47:24]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // out_x [23:0], out_y [47:24]
  output logic        m_tuser,   // merged
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [22:0] cfg_data
);
  import capm_pkg::*;

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  state_t state, state_next;

  logic [THR_W-1:0]  thr;
  logic [CW-1:0]     count;
  logic [CW-1:0]     n;
  logic [CW-1:0]     k;
  logic [CW-1:0]     k_step;
  logic [IW-1:0]     raddr;
  logic [IW-1:0]     best;
  logic              found;
  logic [DIST_W-1:0] best_d;
  logic [DIST_W-1:0] sq_sum;
  logic [SQ_W-1:0]   dx2;
  logic [SQ_W-1:0]   prod;
  logic [T2_W-1:0]   t2;
  logic signed [DIFF_W-1:0] mul_a;
  point_t            mem [MAX_POINTS];
  point_t            rdata;
  point_t            prev;
  point_t            cur;
  point_t            best_a;
  point_t            best_b;
  point_t            best_mid;
  point_t            merge_pt;
  logic              in_acc;
  logic              wr_en;
  logic              out_load;
  logic              take_merge;
  logic              last_n;
  logic              is_better;
  logic [CW-1:0]     n_final;

  assign in_acc    = s_tvalid && s_tready;
  assign wr_en     = in_acc && (count < CW'(MAX_POINTS));
  assign n_final   = wr_en ? count + CW'(1) : count;
  assign cfg_ready = 1'b1;
  assign out_load  = (state == S_EOUT) && (!m_tvalid || m_tready);
  assign take_merge = found && (k == CW'(best));
  assign k_step    = take_merge ? k + CW'(2) : k + CW'(1);
  assign last_n    = (k_step >= n);
  assign is_better = (sq_sum < DIST_W'(t2)) && (!found || sq_sum < best_d);

  always_comb begin
    if (CW'(best) == CW'(0)) begin
      merge_pt = best_a;
    end else if (CW'(best) == n - CW'(2)) begin
      merge_pt = best_b;
    end else begin
      merge_pt = best_mid;
    end
  end

  capm_sq u_sq (
    .clk (clk),
    .a   (mul_a),
    .sq  (prod)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[IW-1:0]] <= s_tdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD: begin
        if (in_acc && s_tlast) begin
          state_next = (n_final >= CW'(MIN_LIST)) ? S_THR : S_ERD;
        end
      end
      S_THR: state_next = S_T2;
      S_T2:  state_next = S_RD;
      S_RD:  state_next = S_DX;
      S_DX:  state_next = (k == CW'(0)) ? S_RD : S_DY;
      S_DY:  state_next = S_ADD;
      S_ADD: state_next = S_CMP;
      S_CMP: state_next = (k == n - CW'(1)) ? S_ERD : S_RD;
      S_ERD: state_next = S_EOUT;
      S_EOUT: begin
        if (out_load) begin
          state_next = last_n ? S_LOAD : S_ERD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    mul_a    = '0;
    raddr    = k[IW-1:0];
    unique case (state)
      S_LOAD: s_tready = 1'b1;
      S_THR:  mul_a = DIFF_W'(thr);
      S_DX:   mul_a = sdiff(rdata.x, prev.x);
      S_DY:   mul_a = sdiff(cur.y, prev.y);
      default: mul_a = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      thr      <= THR_RESET;
      count    <= '0;
      m_tvalid <= 1'b0;
      found    <= 1'b0;
      k        <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        thr <= cfg_data;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (s_tlast) begin
              count <= '0;
              found <= 1'b0;
              k     <= '0;
            end else begin
              count <= n_final;
            end
          end
        end
        S_DX: begin
          if (k == CW'(0)) begin
            k <= CW'(1);
          end
        end
        S_CMP: begin
          if (is_better) begin
            found <= 1'b1;
          end
          k <= (k == n - CW'(1)) ? '0 : k + CW'(1);
        end
        S_EOUT: begin
          if (out_load) begin
            k <= k_step;
          end
        end
        default: k <= k;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LOAD && in_acc && s_tlast) begin
      n <= n_final;
    end
    if (state == S_T2) begin
      t2 <= prod[T2_W-1:0];
    end
    if (state == S_DX) begin
      if (k == CW'(0)) begin
        prev <= rdata;
      end else begin
        cur <= rdata;
      end
    end
    if (state == S_DY) begin
      dx2 <= prod;
    end
    if (state == S_ADD) begin
      sq_sum <= DIST_W'(dx2) + DIST_W'(prod);
    end
    if (state == S_CMP) begin
      prev <= cur;
      if (is_better) begin
        best_d     <= sq_sum;
        best       <= IW'(k - CW'(1));
        best_a     <= prev;
        best_b     <= cur;
        best_mid.x <= floor_mid(prev.x, cur.x);
        best_mid.y <= floor_mid(prev.y, cur.y);
      end
    end
    if (out_load) begin
      m_tdata <= take_merge ? merge_pt : rdata;
      m_tuser <= found;
      m_tlast <= last_n;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_POINTS))
    else $error("point count exceeds the store depth");

  a_best_in_list: assert property (@(posedge clk) disable iff (rst)
    (found && (state == S_ERD || state == S_EOUT)) |-> (CW'(best) + CW'(1) < n))
    else $error("merged pair lies outside the list");

  a_emit_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_EOUT) |-> (k < n))
    else $error("emit index ran past the list");

endmodule

### sim/closest_adjacent_point_merge_tb.sv
`timescale 1ns / 1ps
module closest_adjacent_point_merge_tb;
  import capm_pkg::*;

  localparam int MAX_PTS = 64;
  localparam int RAND_ITEMS = 345;
  localparam int SETTLE = 20;
  localparam int HOLD_CYCLES = 600;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_DIRECTED = 27;
  localparam logic [THR_W-1:0] THR_MAX = '1;
  localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum logic [1:0] {ROW_POINT, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t kind;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic last;
    logic typed;
    logic [THR_W-1:0] thr;
  } stim_row_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic merged;
    logic eol;
  } emitted_point_t;

  logic clk = 0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [47:0] s_tdata;   // point_x [23:0], point_y [47:24]
  logic s_tlast;
  logic m_tvalid;
  logic m_tready;
  logic [47:0] m_tdata;   // out_x [23:0], out_y [47:24]
  logic m_tuser;          // merged
  logic m_tlast;
  logic cfg_valid;
  logic cfg_ready;
  logic [22:0] cfg_data;

  closest_adjacent_point_merge #(
    .MAX_POINTS(MAX_PTS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  logic signed [COORD_W-1:0] poly_x [MAX_PTS];
  logic signed [COORD_W-1:0] poly_y [MAX_PTS];
  int poly_len;
  logic [THR_W-1:0] merge_thr;
  emitted_point_t expected_points[$];
  int errors = 0;
  int cycle_count = 0;
  bit src_calm = 0;
  bit sink_calm = 0;
  bit hold_go = 0;

  stim_row_t directed [N_DIRECTED] = '{
    '{ROW_POINT, C_MAX, C_MIN, 1, 1, 0},
    '{ROW_POINT, 0, 0, 0, 0, 0},
    '{ROW_POINT, 15, 0, 0, 0, 0},
    '{ROW_POINT, 1000, 0, 1, 0, 0},
    '{ROW_POINT, 0, 0, 0, 0, 0},
    '{ROW_POINT, 1000, 0, 0, 0, 0},
    '{ROW_POINT, 1002, 3, 1, 0, 0},
    '{ROW_POINT, 0, 0, 0, 0, 0},
    '{ROW_POINT, -100, -3, 0, 0, 0},
    '{ROW_POINT, -103, -6, 0, 0, 0},
    '{ROW_POINT, -1000, 0, 1, 0, 0},
    '{ROW_POINT, 0, 0, 0, 0, 0},
    '{ROW_POINT, 500, 0, 0, 0, 0},
    '{ROW_POINT, 503, 0, 0, 0, 0},
    '{ROW_POINT, 1000, 0, 0, 0, 0},
    '{ROW_POINT, 1003, 0, 0, 0, 0},
    '{ROW_POINT, 2000, 0, 1, 0, 0},
    '{ROW_CFG, 0, 0, 0, 0, 0},
    '{ROW_POINT, 7, 7, 0, 0, 0},
    '{ROW_POINT, 7, 7, 0, 0, 0},
    '{ROW_POINT, 7, 7, 1, 0, 0},
    '{ROW_CFG, 0, 0, 0, 0, THR_MAX},
    '{ROW_POINT, C_MAX, C_MAX, 0, 0, 0},
    '{ROW_POINT, C_MIN, C_MIN, 0, 0, 0},
    '{ROW_POINT, C_MAX, C_MIN, 0, 0, 0},
    '{ROW_POINT, C_MAX, -1, 0, 0, 0},
    '{ROW_POINT, 1, 0, 1, 0, 0}
  };

  task automatic queue_expected(input emitted_point_t r);
    expected_points.insert(expected_points.size(), r);
  endtask

  task automatic take_point(input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
                            input logic last, input logic predict);
    int n, best, k;
    bit found;
    longint t2, d, dx, dy, best_d;
    logic signed [COORD_W-1:0] mx, my;
    emitted_point_t r;
    if (poly_len < MAX_PTS) begin
      poly_x[poly_len] = x;
      poly_y[poly_len] = y;
      poly_len++;
    end
    if (!last) return;
    n = poly_len;
    poly_len = 0;
    found = 0;
    best = 0;
    best_d = 0;
    if (n >= MIN_LIST) begin
      t2 = longint'(merge_thr) * longint'(merge_thr);
      for (int i = 0; i + 1 < n; i++) begin
        dx = longint'(poly_x[i]) - longint'(poly_x[i+1]);
        dy = longint'(poly_y[i]) - longint'(poly_y[i+1]);
        d = dx * dx + dy * dy;
        if (d < t2 && (!found || d < best_d)) begin
          found = 1;
          best_d = d;
          best = i;
        end
      end
    end
    if (found) begin
      if (best == 0) begin
        mx = poly_x[0];
        my = poly_y[0];
      end else if (best == n - 2) begin
        mx = poly_x[n-1];
        my = poly_y[n-1];
      end else begin
        mx = COORD_W'((longint'(poly_x[best]) + longint'(poly_x[best+1])) >>> 1);
        my = COORD_W'((longint'(poly_y[best]) + longint'(poly_y[best+1])) >>> 1);
      end
    end
    if (!predict) return;
    k = 0;
    while (k < n) begin
      if (found && k == best) begin
        r.x = mx;
        r.y = my;
        k += 2;
      end else begin
        r.x = poly_x[k];
        r.y = poly_y[k];
        k += 1;
      end
      r.merged = found;
      r.eol = (k >= n);
      queue_expected(r);
    end
  endtask

  task automatic send_point(input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
                            input logic last, input logic typed);
    emitted_point_t r;
    if (!src_calm) begin
      while ($urandom_range(0, 99) < 35) begin
        s_tvalid = 0;
        @(negedge clk);
      end
    end
    s_tdata = {y, x};
    s_tlast = last;
    s_tvalid = 1;
    do @(posedge clk); while (!s_tready);
    take_point(x, y, last, !typed);
    if (typed) begin
      r.x = x;
      r.y = y;
      r.merged = 0;
      r.eol = 1;
      queue_expected(r);
    end
    @(negedge clk);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] v);
    s_tvalid = 0;
    s_tlast = 0;
    while (expected_points.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_data = v;
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    merge_thr = v;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // A request on the output side is taken at a rising edge with valid and ready high.
  always @(posedge clk) begin
    emitted_point_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.x = m_tdata[23:0];
      got.y = m_tdata[47:24];
      got.merged = m_tuser;
      got.eol = m_tlast;
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected point x=%h y=%h merged=%b last=%b",
                 $time, got.x, got.y, got.merged, got.eol);
        errors++;
      end else begin
        want = expected_points.pop_front();
        if (got !== want) begin
          $display("%0t: expected x=%h y=%h merged=%b last=%b, actual x=%h y=%h merged=%b last=%b",
                   $time, want.x, want.y, want.merged, want.eol,
                   got.x, got.y, got.merged, got.eol);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("closest_adjacent_point_merge_tb NOT OK");
      $finish;
    end
  end

  initial begin
    int hold_left;
    hold_left = 0;
    m_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        m_tready = 0;
        hold_left--;
      end else begin
        m_tready = sink_calm || ($urandom_range(0, 99) >= 35);
      end
    end
  end

  initial begin
    int items, phase, len, span;
    logic [THR_W-1:0] thr;
    logic signed [COORD_W-1:0] cx, cy;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    s_tlast = 0;
    cfg_valid = 0;
    cfg_data = '0;
    poly_len = 0;
    merge_thr = THR_RESET;
    cx = '0;
    cy = '0;
    repeat (2) @(negedge clk);
    rst = 0;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        write_threshold(directed[i].thr);
      end else begin
        send_point(directed[i].x, directed[i].y, directed[i].last, directed[i].typed);
      end
    end

    items = 0;
    phase = 0;
    while (items < RAND_ITEMS) begin
      case ($urandom_range(0, 5)) inside
        0: thr = THR_W'($urandom_range(0, 8));
        1, 2: thr = THR_W'($urandom_range(8, 64));
        3: thr = THR_W'($urandom_range(64, 2000));
        4: thr = THR_W'($urandom);
        default: thr = (phase % 2) ? THR_MAX : '0;
      endcase
      write_threshold(thr);
      span = (thr > 2000) ? 4000 : 2 * int'(thr) + 2;
      src_calm = (phase == 4);
      sink_calm = (phase == 4);
      if (phase == 2) hold_go = 1;
      for (int l = 0; l < 4; l++) begin
        if (l == 0 && (phase == 1 || phase == 5)) begin
          len = (phase == 1) ? MAX_PTS : MAX_PTS + 3;
        end else begin
          len = $urandom_range(1, 9);
        end
        for (int p = 0; p < len; p++) begin
          case ((p == 0) ? 0 : $urandom_range(0, 19))
            0: begin
              cx = COORD_W'($urandom);
              cy = COORD_W'($urandom);
            end
            1: begin
              cx = $urandom_range(0, 1) ? C_MAX : C_MIN;
              cy = $urandom_range(0, 1) ? C_MAX : C_MIN;
            end
            2: ;
            default: begin
              cx = COORD_W'(cx + $urandom_range(0, 2 * span) - span);
              cy = COORD_W'(cy + $urandom_range(0, 2 * span) - span);
            end
          endcase
          send_point(cx, cy, p == len - 1, 0);
          items++;
        end
      end
      phase++;
    end
    src_calm = 0;
    sink_calm = 0;

    s_tvalid = 0;
    s_tlast = 0;
    while (expected_points.size() != 0) @(negedge clk);
    repeat (2 * SETTLE) @(negedge clk);
    if (errors == 0) begin
      $display("closest_adjacent_point_merge_tb OK");
    end else begin
      $display("closest_adjacent_point_merge_tb NOT OK");
    end
    $finish;
  end

endmodule
